### hw/rtl/itoa_pkg.sv
// itoa_pkg: types and constants shared by the integer-to-decimal text block.
// Command and status structs that join the controller and the datapath.
// No dependencies.
package itoa_pkg;

	localparam logic [7:0] CHAR_ZERO     = 8'd48;
	localparam logic [7:0] CHAR_MINUS    = 8'd45;
	localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [3:0] DIGIT_ADJ     = 4'd3;

	typedef struct packed {
		logic load;
		logic shift;
		logic find;
		logic emit_sign;
		logic emit_digit;
	} itoa_cmd_t;

	typedef struct packed {
		logic bit_last;
		logic negative;
		logic dig_last;
		logic out_free;
	} itoa_status_t;

endpackage

### hw/rtl/itoa_datapath.sv
// itoa_datapath: magnitude, shift-and-add-3 BCD register, digit pointer and output register.
// Acts on commands from itoa_ctrl; reports status back.
// Depends on itoa_pkg.
module itoa_datapath #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  itoa_pkg::itoa_cmd_t           cmd,
	output itoa_pkg::itoa_status_t        st,
	output logic                          character_valid,
	input  logic                          character_stall,
	output logic [7:0]                    character,
	output logic                          is_last
);
	import itoa_pkg::*;

	localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int BW   = NDIG * 4;
	localparam int BCW  = $clog2(VALUE_WIDTH);
	localparam int DIW  = $clog2(NDIG);

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          bcd_adj;
	logic                   neg_q;
	logic [BCW-1:0]         bit_cnt_q;
	logic [DIW-1:0]         dig_idx_q;
	logic [DIW-1:0]         msd;
	logic [3:0]             cur_nib;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	assign raw    = $unsigned(value);
	assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

	always_comb begin
		logic [3:0] nib;
		nib = '0;
		for (int i = 0; i < NDIG; i++) begin
			nib = bcd_q[i*4 +: 4];
			bcd_adj[i*4 +: 4] = (nib >= DIGIT_ADJ_MIN) ? nib + DIGIT_ADJ : nib;
		end
	end

	// leading non-zero digit, digit 0 when all are zero
	always_comb begin
		msd = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				msd = DIW'(i);
			end
		end
	end

	assign cur_nib = bcd_q[dig_idx_q*4 +: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q     <= mag_in;
			bcd_q     <= '0;
			neg_q     <= raw[VALUE_WIDTH-1];
			bit_cnt_q <= BCW'(VALUE_WIDTH - 1);
		end else if (cmd.shift) begin
			bcd_q     <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end
		if (cmd.find) begin
			dig_idx_q <= msd;
		end else if (cmd.emit_digit) begin
			dig_idx_q <= dig_idx_q - 1'b1;
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + {4'd0, cur_nib};
			last_q <= (dig_idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!character_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.bit_last = (bit_cnt_q == '0);
	assign st.negative = neg_q;
	assign st.dig_last = (dig_idx_q == '0);
	assign st.out_free = !out_valid_q || !character_stall;

	assign character_valid = out_valid_q;
	assign character       = char_q;
	assign is_last         = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> st.out_free)
		else $error("waiting item overwritten");

	a_load_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (bit_cnt_q == BCW'(VALUE_WIDTH - 1)) && (bcd_q == '0))
		else $error("conversion not initialised on load");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit && dig_idx_q == '0) |=> (is_last && character_valid))
		else $error("final digit lacks last flag");

endmodule

### hw/rtl/itoa_ctrl.sv
// itoa_ctrl: sequencing state machine for the integer-to-decimal text block.
// Drives itoa_datapath by command struct, reads its status.
// Depends on itoa_pkg.
module itoa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   value_valid,
	output logic                   value_stall,
	input  itoa_pkg::itoa_status_t st,
	output itoa_pkg::itoa_cmd_t    cmd
);
	import itoa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CONV  = 5'b00010,
		S_FIND  = 5'b00100,
		S_SIGN  = 5'b01000,
		S_DIGIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (value_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.shift = 1'b1;
				if (st.bit_last) begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				cmd.find = 1'b1;
				state_d  = st.negative ? S_SIGN : S_DIGIT;
			end
			S_SIGN: begin
				if (st.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (st.out_free) begin
					cmd.emit_digit = 1'b1;
					if (st.dig_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign value_stall = (state_q != S_IDLE);

	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sign |-> st.negative)
		else $error("minus sign for non-negative value");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT && cmd.emit_digit && st.dig_last) |=> state_q == S_IDLE)
		else $error("no return to idle after final digit");

	a_conv_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && !st.bit_last) |=> state_q == S_CONV)
		else $error("conversion cut short");

endmodule

### hw/rtl/int_to_decimal_ascii_top.sv
// int_to_decimal_ascii_top: signed integer to decimal ASCII text, top level.
// Instantiates itoa_ctrl and itoa_datapath.
// Depends on itoa_pkg.
//
// Each accepted value is turned into its decimal text, one character per output item,
// most significant first: a minus sign (45) first for negative values, then digits
// 48..57 with no leading zeros; zero gives a single '0'. is_last marks the final
// character. The most negative value is converted exactly. An item passes through a load
// of the value, VALUE_WIDTH shift-and-add-3 steps of the BCD register, a step that locates
// the leading digit, then one character per cycle while the output side does not stall.
// A new value is taken once the last character of the previous one has been loaded into
// the output register.
module int_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          character_valid,
	input  logic                          character_stall,
	output logic [7:0]                    character,
	output logic                          is_last
);
	import itoa_pkg::*;

	itoa_cmd_t    cmd;
	itoa_status_t st;

	itoa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.st          (st),
		.cmd         (cmd)
	);

	itoa_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.value           (value),
		.cmd             (cmd),
		.st              (st),
		.character_valid (character_valid),
		.character_stall (character_stall),
		.character       (character),
		.is_last         (is_last)
	);

endmodule

### sim/tb_int_to_decimal_ascii_top.sv
`timescale 1ns / 100ps
// tb_int_to_decimal_ascii_top: self-checking testbench for int_to_decimal_ascii_top.
// Predicts the decimal text of each accepted value and checks every character item.
// Depends on itoa_pkg and int_to_decimal_ascii_top.
module tb_int_to_decimal_ascii_top;
	import itoa_pkg::*;

	localparam int VW = 32;
	localparam int NUM_PHASES = 4;
	localparam int RANDOM_PER_PHASE = 48;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 60;
	localparam logic [VW-1:0] DIRECTED [21] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
		32'hC465_3601, 32'd1234567890, 32'hB669_FD2E, 32'h5555_5555, 32'hAAAA_AAAA,
		32'd7, 32'hFFFF_FFFB, 32'd2147483638
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 value_valid = 1'b0;
	logic                 value_stall;
	logic signed [VW-1:0] value = '0;
	logic                 character_valid;
	logic                 character_stall = 1'b0;
	logic [7:0]           character;
	logic                 is_last;

	logic [VW-1:0] values_to_send [$];
	text_char_t    expected_chars [$];
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   idle_plan [NUM_PHASES] = '{0, 75, 0, 18};
	int unsigned   stall_plan [NUM_PHASES] = '{0, 0, 75, 18};
	int            failures = 0;
	int            quiet_cycles = 0;

	int_to_decimal_ascii_top #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.value_valid(value_valid),
		.value_stall(value_stall),
		.value(value),
		.character_valid(character_valid),
		.character_stall(character_stall),
		.character(character),
		.is_last(is_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// decimal text of one value; magnitude kept one bit wider for the most negative value
	function automatic void predict_decimal_text(input logic [VW-1:0] v);
		logic [VW:0] mag;
		logic [3:0]  digits [$];
		text_char_t  c;
		mag = v[VW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
		if (v[VW-1]) begin
			c.ch = CHAR_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		do begin
			digits.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		foreach (digits[i]) begin
			c.ch = CHAR_ZERO + 8'(digits[i]);
			c.last = (i == digits.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic logic [VW-1:0] random_value();
		logic [VW-1:0] v;
		int unsigned   scale;
		scale = 1;
		case ($urandom_range(0, 3))
			0: v = $urandom();
			1: v = $urandom_range(0, 99);
			2: begin
				repeat ($urandom_range(1, 9)) scale *= 10;
				v = $urandom_range(0, scale);
			end
			default: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
				: 32'h7FFF_FFFF - $urandom_range(0, 15);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid <= 1'b0;
			value <= '0;
		end else if (!value_valid || !value_stall) begin
			if (value_valid)
				predict_decimal_text(value);
			if (values_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				value_valid <= 1'b1;
				value <= values_to_send.pop_front();
			end else begin
				value_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			character_stall <= 1'b0;
		end else begin
			if (character_valid && !character_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected character item: character %0d is_last %0b",
						character, is_last);
					failures++;
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.ch) begin
						$error("character: expected %0d, got %0d", want.ch, character);
						failures++;
					end
					if (is_last !== want.last) begin
						$error("is_last: expected %0b, got %0b", want.last, is_last);
						failures++;
					end
				end
			end
			character_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_valid && !value_stall) || (character_valid && !character_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			@(negedge clk);
			send_idle_pct = idle_plan[p];
			recv_stall_pct = stall_plan[p];
			if (p == 0)
				foreach (DIRECTED[i]) values_to_send.push_back(DIRECTED[i]);
			repeat (RANDOM_PER_PHASE) values_to_send.push_back(random_value());
			// hold the next phase back until all text has been received
			while (values_to_send.size() != 0 || value_valid || expected_chars.size() != 0)
				@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$error("%0d expected characters never arrived", expected_chars.size());
			failures++;
		end
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### int_to_decimal_ascii_top.f
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_datapath.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/int_to_decimal_ascii_top.sv
sim/tb_int_to_decimal_ascii_top.sv
